>>> rtl/bounded_id_set_core_assert.svh
// Assertion macros for the bounded id set core.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef BOUNDED_ID_SET_CORE_ASSERT_SVH
`define BOUNDED_ID_SET_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define BIS_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define BIS_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`else
`define BIS_ASSERT(name, clk, rst_n, prop, msg)
`define BIS_ASSERT_IMP(name, clk, rst_n, ante, cons, msg)
`endif

`endif

>>> rtl/bis_pkg.sv
// Shared types for the bounded id set core: request codes and the
// controller/datapath command and status bundles. No dependencies.
`default_nettype none

package bis_pkg;

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_LOOKUP = 2'd2,
    REQ_READ   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    RD_SCAN = 2'd0,
    RD_LAST = 2'd1,
    RD_POS  = 2'd2
  } rd_sel_e;

  typedef struct packed {
    logic    accept;
    logic    scan;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    wr_append;
    logic    wr_move;
    logic    set_err;
    logic    set_found;
    logic    set_value;
    logic    load_out;
  } cmd_t;

  typedef struct packed {
    req_e req;
    logic id_null;
    logic full;
    logic pos_ok;
    logic hit;
    logic exhausted;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

>>> rtl/bis_ctrl.sv
// Controller for the bounded id set core: sequences decode, table scan,
// delete move, read by position and result hand-off. Depends on bis_pkg.
`default_nettype none

module bis_ctrl (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  input  bis_pkg::sts_t     sts_i,
  output bis_pkg::cmd_t     cmd_o
);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_DECODE = 7'b0000010,
    ST_SCAN   = 7'b0000100,
    ST_DEL_RD = 7'b0001000,
    ST_DEL_WR = 7'b0010000,
    ST_RD_POS = 7'b0100000,
    ST_DONE   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.rd_sel = bis_pkg::RD_SCAN;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (sts_i.req)
          bis_pkg::REQ_ADD: begin
            if (sts_i.id_null || sts_i.full) begin
              cmd_o.set_err = 1'b1;
              state_d       = ST_DONE;
            end else begin
              state_d = ST_SCAN;
            end
          end
          bis_pkg::REQ_DELETE: begin
            if (sts_i.id_null) begin
              cmd_o.set_err = 1'b1;
              state_d       = ST_DONE;
            end else begin
              state_d = ST_SCAN;
            end
          end
          bis_pkg::REQ_LOOKUP: begin
            state_d = sts_i.id_null ? ST_DONE : ST_SCAN;
          end
          default: begin
            if (sts_i.pos_ok) begin
              state_d = ST_RD_POS;
            end else begin
              cmd_o.set_err = 1'b1;
              state_d       = ST_DONE;
            end
          end
        endcase
      end
      ST_SCAN: begin
        cmd_o.scan   = 1'b1;
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = bis_pkg::RD_SCAN;
        if (sts_i.hit) begin
          case (sts_i.req)
            bis_pkg::REQ_DELETE: state_d = ST_DEL_RD;
            bis_pkg::REQ_LOOKUP: begin
              cmd_o.set_found = 1'b1;
              state_d         = ST_DONE;
            end
            default: state_d = ST_DONE;
          endcase
        end else if (sts_i.exhausted) begin
          // append on a miss; delete and lookup of an absent id just report
          cmd_o.wr_append = (sts_i.req == bis_pkg::REQ_ADD);
          state_d         = ST_DONE;
        end
      end
      ST_DEL_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = bis_pkg::RD_LAST;
        state_d      = ST_DEL_WR;
      end
      ST_DEL_WR: begin
        cmd_o.wr_move = 1'b1;
        state_d       = ST_DONE;
      end
      ST_RD_POS: begin
        cmd_o.rd_en     = 1'b1;
        cmd_o.rd_sel    = bis_pkg::RD_POS;
        cmd_o.set_value = 1'b1;
        state_d         = ST_DONE;
      end
      ST_DONE: begin
        // hold the result until the output register frees up
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/bis_dp.sv
// Datapath for the bounded id set core: id table, count, null id register,
// scan pointer and output register. Depends on bis_pkg and the assertion header.
`default_nettype none

`include "bounded_id_set_core_assert.svh"

module bis_dp #(
  parameter int CAPACITY = 16,
  parameter int ID_WIDTH = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  input  wire logic [1:0]  req_type_i,
  input  wire logic [31:0] element_id_i,
  input  wire logic [3:0]  position_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             status_o,
  output logic             found_o,
  output logic [3:0]       found_position_o,
  output logic [31:0]      entry_value_o,
  output logic [4:0]       element_count_o,
  output logic             is_full_o,
  output logic             is_empty_o,
  input  bis_pkg::cmd_t    cmd_i,
  output bis_pkg::sts_t    sts_o
);

  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int WIDE_W = (CNT_W > 5) ? CNT_W : 5;
  localparam int VAL_W  = (ID_WIDTH > 32) ? ID_WIDTH : 32;
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  logic [ID_WIDTH-1:0] mem [CAPACITY];

  bis_pkg::req_e       req_q;
  logic [ID_WIDTH-1:0] id_q;
  logic [3:0]          pos_q;
  logic [31:0]         null_q;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [CNT_W-1:0]    idx_q, idx_d;
  logic                pend_q, pend_d;
  logic [IDX_W-1:0]    pend_idx_q;
  logic [IDX_W-1:0]    found_idx_q;
  logic [ID_WIDTH-1:0] rdata_q;
  logic                err_q, found_q, value_q;
  logic                out_valid_q, out_valid_d;
  logic                out_status_q, out_found_q, out_full_q, out_empty_q;
  logic [3:0]          out_fpos_q;
  logic [31:0]         out_value_q;
  logic [4:0]          out_count_q;

  logic [VAL_W-1:0]    id_ext, null_ext, rdata_ext;
  logic [ID_WIDTH-1:0] null_id;
  logic [WIDE_W-1:0]   cnt_ext, fidx_ext;
  logic [CNT_W-1:0]    cnt_m1;
  logic                issue, out_free;
  logic [IDX_W-1:0]    raddr, waddr;
  logic [ID_WIDTH-1:0] wdata;
  logic                we;

  assign id_ext    = VAL_W'(element_id_i);
  assign null_ext  = VAL_W'(null_q);
  assign null_id   = null_ext[ID_WIDTH-1:0];
  assign rdata_ext = VAL_W'(rdata_q);
  assign cnt_ext   = WIDE_W'(count_q);
  assign fidx_ext  = WIDE_W'(found_idx_q);
  assign cnt_m1    = count_q - 1'b1;
  assign issue     = cmd_i.scan && (idx_q < count_q);
  assign out_free  = !out_valid_q || !out_stall_i;

  assign sts_o.req       = req_q;
  assign sts_o.id_null   = (id_q == null_id);
  assign sts_o.full      = (count_q >= CAP_CNT);
  assign sts_o.pos_ok    = (WIDE_W'(pos_q) < cnt_ext);
  assign sts_o.hit       = pend_q && (rdata_q == id_q);
  assign sts_o.exhausted = !pend_q && (idx_q >= count_q);
  assign sts_o.out_free  = out_free;

  // table port select
  always_comb begin
    case (cmd_i.rd_sel)
      bis_pkg::RD_LAST: raddr = cnt_m1[IDX_W-1:0];
      bis_pkg::RD_POS:  raddr = pos_q[IDX_W-1:0];
      default:          raddr = idx_q[IDX_W-1:0];
    endcase
    we    = cmd_i.wr_append || cmd_i.wr_move;
    waddr = cmd_i.wr_move ? found_idx_q : count_q[IDX_W-1:0];
    wdata = cmd_i.wr_move ? rdata_q : id_q;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[raddr];
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.wr_append) begin
      count_d = count_q + 1'b1;
    end else if (cmd_i.wr_move) begin
      count_d = cnt_m1;
    end
    idx_d  = idx_q;
    pend_d = pend_q;
    if (cmd_i.accept) begin
      idx_d  = '0;
      pend_d = 1'b0;
    end else if (cmd_i.scan) begin
      idx_d  = idx_q + CNT_W'(issue);
      pend_d = issue;
    end
    out_valid_d = cmd_i.load_out ? 1'b1 : (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      null_q      <= '1;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      err_q       <= 1'b0;
      found_q     <= 1'b0;
      value_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      idx_q       <= idx_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        null_q <= cfg_wdata_i;
      end
      if (cmd_i.accept) begin
        err_q   <= 1'b0;
        found_q <= 1'b0;
        value_q <= 1'b0;
      end else begin
        err_q   <= err_q   | cmd_i.set_err;
        found_q <= found_q | cmd_i.set_found;
        value_q <= value_q | cmd_i.set_value;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_q <= bis_pkg::req_e'(req_type_i);
      id_q  <= id_ext[ID_WIDTH-1:0];
      pos_q <= position_i;
    end
    if (issue) begin
      pend_idx_q <= idx_q[IDX_W-1:0];
    end
    if (cmd_i.scan && sts_o.hit) begin
      found_idx_q <= pend_idx_q;
    end
    if (cmd_i.load_out) begin
      out_status_q <= err_q;
      out_found_q  <= found_q;
      out_fpos_q   <= found_q ? fidx_ext[3:0] : 4'd0;
      out_value_q  <= value_q ? rdata_ext[31:0] : 32'd0;
      out_count_q  <= cnt_ext[4:0];
      out_full_q   <= (count_q == CAP_CNT);
      out_empty_q  <= (count_q == '0);
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign found_o          = out_found_q;
  assign found_position_o = out_fpos_q;
  assign entry_value_o    = out_value_q;
  assign element_count_o  = out_count_q;
  assign is_full_o        = out_full_q;
  assign is_empty_o       = out_empty_q;

  `BIS_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CAP_CNT, "count above capacity")
  `BIS_ASSERT_IMP(a_append_room, clk_i, rst_ni, cmd_i.wr_append, count_q < CAP_CNT, "append when full")
  `BIS_ASSERT_IMP(a_move_nonempty, clk_i, rst_ni, cmd_i.wr_move, count_q != '0, "move on empty table")
  `BIS_ASSERT_IMP(a_load_free, clk_i, rst_ni, cmd_i.load_out, out_free, "result overwrites a stalled one")

endmodule

`default_nettype wire

>>> rtl/bounded_id_set_core.sv
// Bounded id set core: a packed table of up to CAPACITY identifiers with a
// count, serving add, delete, lookup and read-by-position requests one at a
// time with one result per request. Add, delete and lookup scan the table
// through its single read port, one entry per cycle; a delete that hits then
// moves the last entry into the freed slot; rejected requests and reads skip
// the scan. A finished result waits in the output register while the next
// request is already taken. The null id register resets to all ones.
// Depends on bis_pkg, bis_ctrl and bis_dp.
`default_nettype none

module bounded_id_set_core #(
  parameter int CAPACITY = 16,
  parameter int ID_WIDTH = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  req_type_i,
  input  wire logic [31:0] element_id_i,
  input  wire logic [3:0]  position_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             status_o,
  output logic             found_o,
  output logic [3:0]       found_position_o,
  output logic [31:0]      entry_value_o,
  output logic [4:0]       element_count_o,
  output logic             is_full_o,
  output logic             is_empty_o
);

  bis_pkg::cmd_t cmd;
  bis_pkg::sts_t sts;

  bis_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bis_dp #(
    .CAPACITY (CAPACITY),
    .ID_WIDTH (ID_WIDTH)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .req_type_i       (req_type_i),
    .element_id_i     (element_id_i),
    .position_i       (position_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .found_o          (found_o),
    .found_position_o (found_position_o),
    .entry_value_o    (entry_value_o),
    .element_count_o  (element_count_o),
    .is_full_o        (is_full_o),
    .is_empty_o       (is_empty_o),
    .cmd_i            (cmd),
    .sts_o            (sts)
  );

endmodule

`default_nettype wire
